// ===== rtl/tcat_pkg.sv =====
// ----------------------------------------------------------------------------
// tcat_pkg
// Types, field widths and default sizes shared by the address translator.
// ----------------------------------------------------------------------------
package tcat_pkg;

    // default store sizes
    localparam int DEF_TLB_SETS     = 4;
    localparam int DEF_TLB_WAYS     = 4;
    localparam int DEF_PAGE_ENTRIES = 256;
    localparam int DEF_CACHE_LINES  = 16;

    // fixed field widths
    localparam int KIND_W  = 2;
    localparam int VA_W    = 14;
    localparam int SET_W   = 2;
    localparam int TAG_W   = 6;
    localparam int VPN_W   = 8;
    localparam int PPN_W   = 6;
    localparam int LIDX_W  = 4;
    localparam int LDATA_W = 32;
    localparam int BYTE_W  = 8;
    localparam int OFFS_W  = 2;

    // virtual address layout
    localparam int VA_TAG_LSB  = 8;
    localparam int VA_VPN_LSB  = 6;
    localparam int VA_LINE_LSB = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ      = 2'd0,
        KIND_LOAD_TLB  = 2'd1,
        KIND_LOAD_PAGE = 2'd2,
        KIND_LOAD_LINE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_kind                kind;
        logic [VA_W-1:0]      virtual_address;
        logic [SET_W-1:0]     tlb_set;
        logic [TAG_W-1:0]     entry_tag;
        logic [VPN_W-1:0]     virtual_page;
        logic [PPN_W-1:0]     physical_page;
        logic [LIDX_W-1:0]    line_index;
        logic [LDATA_W-1:0]   line_data;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0]    data_byte;
        logic                 determined;
        logic [PPN_W-1:0]     translated_page;
    } t_rsp;

    typedef struct packed {
        logic                 valid;
        logic [TAG_W-1:0]     tag;
        logic [PPN_W-1:0]     page;
    } t_tlb_ent;

    typedef struct packed {
        logic                 valid;
        logic [TAG_W-1:0]     tag;
        logic [LDATA_W-1:0]   data;
    } t_line_ent;

    // controller -> datapath
    typedef struct packed {
        logic clr_en;
        logic capture;
        logic pt_wr;
        logic line_wr;
        logic tlb_fill;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/tcat_if.sv =====
// ----------------------------------------------------------------------------
// tcat_if
// Valid/ready channels for requests and responses of the address translator.
// ----------------------------------------------------------------------------
interface tcat_req_if;
    import tcat_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tcat_rsp_if;
    import tcat_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/tcat_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcat_ctrl
// Sequencer: clearing pass after reset, request capture, execute step.
// ----------------------------------------------------------------------------
module tcat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  tcat_pkg::t_kind   i_req_kind,
    input  tcat_pkg::t_dp_sts i_sts,
    output logic              o_req_ready,
    output tcat_pkg::t_dp_cmd o_cmd
);
    import tcat_pkg::*;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_kind  <= KIND_READ;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind = i_req_kind;
                    if (i_req_kind inside {KIND_READ, KIND_LOAD_TLB})
                        n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_kind == KIND_LOAD_TLB || i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.pt_wr   = (i_req_kind == KIND_LOAD_PAGE);
                    o_cmd.line_wr = (i_req_kind == KIND_LOAD_LINE);
                end
            end
            S_EXEC: begin
                if (r_kind == KIND_LOAD_TLB) o_cmd.tlb_fill = 1'b1;
                else if (i_sts.out_free)     o_cmd.out_load = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/tcat_dp.sv =====
// ----------------------------------------------------------------------------
// tcat_dp
// Datapath: TLB way memories, page table, cache line memory, compare logic
// and the response register.
// ----------------------------------------------------------------------------
module tcat_dp #(
    parameter int TLB_SETS     = tcat_pkg::DEF_TLB_SETS,
    parameter int TLB_WAYS     = tcat_pkg::DEF_TLB_WAYS,
    parameter int PAGE_ENTRIES = tcat_pkg::DEF_PAGE_ENTRIES,
    parameter int CACHE_LINES  = tcat_pkg::DEF_CACHE_LINES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcat_pkg::t_dp_cmd i_cmd,
    input  tcat_pkg::t_req    i_req,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    output tcat_pkg::t_rsp    o_rsp,
    output tcat_pkg::t_dp_sts o_sts
);
    import tcat_pkg::*;

    localparam int TLB_AW  = (TLB_SETS > 1) ? $clog2(TLB_SETS) : 1;
    localparam int PT_AW   = $clog2(PAGE_ENTRIES);
    localparam int LINE_AW = $clog2(CACHE_LINES);
    localparam int CLR_DEPTH_A = (TLB_SETS > PAGE_ENTRIES) ? TLB_SETS : PAGE_ENTRIES;
    localparam int CLR_DEPTH   = (CACHE_LINES > CLR_DEPTH_A) ? CACHE_LINES : CLR_DEPTH_A;
    localparam int CLR_W       = $clog2(CLR_DEPTH);

    // index wrap tables
    logic [TLB_AW-1:0]  w_set_map  [1 << SET_W];
    logic [PT_AW-1:0]   w_pt_map   [1 << VPN_W];
    logic [LINE_AW-1:0] w_line_map [1 << LIDX_W];

    for (genvar i = 0; i < (1 << SET_W); i++) begin : g_set_map
        assign w_set_map[i] = TLB_AW'(i % TLB_SETS);
    end
    for (genvar i = 0; i < (1 << VPN_W); i++) begin : g_pt_map
        assign w_pt_map[i] = PT_AW'(i % PAGE_ENTRIES);
    end
    for (genvar i = 0; i < (1 << LIDX_W); i++) begin : g_line_map
        assign w_line_map[i] = LINE_AW'(i % CACHE_LINES);
    end

    // clearing pass counter
    logic [CLR_W-1:0] r_clr_idx;
    logic             w_clr_tlb, w_clr_pt, w_clr_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    assign w_clr_tlb  = i_cmd.clr_en && ({1'b0, r_clr_idx} < (CLR_W+1)'(TLB_SETS));
    assign w_clr_pt   = i_cmd.clr_en && ({1'b0, r_clr_idx} < (CLR_W+1)'(PAGE_ENTRIES));
    assign w_clr_line = i_cmd.clr_en && ({1'b0, r_clr_idx} < (CLR_W+1)'(CACHE_LINES));

    // latched request fields
    logic [TAG_W-1:0]  r_va_tag;
    logic [OFFS_W-1:0] r_offset;
    logic [TAG_W-1:0]  r_fill_tag;
    logic [PPN_W-1:0]  r_fill_page;
    logic [TLB_AW-1:0] r_set_idx;
    logic [TLB_AW-1:0] w_rd_set;

    assign w_rd_set = (i_req.kind == KIND_READ)
                    ? w_set_map[i_req.virtual_address[VA_VPN_LSB +: SET_W]]
                    : w_set_map[i_req.tlb_set];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_va_tag    <= i_req.virtual_address[VA_TAG_LSB +: TAG_W];
            r_offset    <= i_req.virtual_address[OFFS_W-1:0];
            r_fill_tag  <= i_req.entry_tag;
            r_fill_page <= i_req.physical_page;
            r_set_idx   <= w_rd_set;
        end
    end

    // TLB: one memory per way, indexed by set
    t_tlb_ent          w_tlb_rd [TLB_WAYS];
    logic [TLB_WAYS-1:0] w_fill_way;
    logic [TLB_AW-1:0] w_tlb_waddr;
    t_tlb_ent          w_tlb_wdata;

    assign w_tlb_waddr = i_cmd.clr_en ? TLB_AW'(r_clr_idx) : r_set_idx;
    assign w_tlb_wdata = i_cmd.clr_en ? t_tlb_ent'('0)
                                      : t_tlb_ent'{valid: 1'b1, tag: r_fill_tag,
                                                   page: r_fill_page};

    for (genvar g = 0; g < TLB_WAYS; g++) begin : g_way
        t_tlb_ent r_mem [TLB_SETS];
        t_tlb_ent r_rd;
        logic     w_we;

        assign w_we = w_clr_tlb || (i_cmd.tlb_fill && w_fill_way[g]);

        always_ff @(posedge i_clk) begin
            if (w_we) r_mem[w_tlb_waddr] <= w_tlb_wdata;
            if (i_cmd.capture) r_rd <= r_mem[w_rd_set];
        end

        assign w_tlb_rd[g] = r_rd;
    end

    // page table
    logic [PPN_W-1:0] r_pt_mem [PAGE_ENTRIES];
    logic [PPN_W-1:0] r_pt_rd;
    logic [PT_AW-1:0] w_pt_waddr;

    assign w_pt_waddr = i_cmd.clr_en ? PT_AW'(r_clr_idx) : w_pt_map[i_req.virtual_page];

    always_ff @(posedge i_clk) begin
        if (w_clr_pt || i_cmd.pt_wr)
            r_pt_mem[w_pt_waddr] <= i_cmd.clr_en ? '0 : i_req.physical_page;
        if (i_cmd.capture)
            r_pt_rd <= r_pt_mem[w_pt_map[i_req.virtual_address[VA_VPN_LSB +: VPN_W]]];
    end

    // cache lines
    t_line_ent          r_line_mem [CACHE_LINES];
    t_line_ent          r_line_rd;
    logic [LINE_AW-1:0] w_line_waddr;

    assign w_line_waddr = i_cmd.clr_en ? LINE_AW'(r_clr_idx) : w_line_map[i_req.line_index];

    always_ff @(posedge i_clk) begin
        if (w_clr_line || i_cmd.line_wr)
            r_line_mem[w_line_waddr] <= i_cmd.clr_en ? t_line_ent'('0)
                : t_line_ent'{valid: 1'b1, tag: i_req.entry_tag, data: i_req.line_data};
        if (i_cmd.capture)
            r_line_rd <= r_line_mem[w_line_map[i_req.virtual_address[VA_LINE_LSB +: LIDX_W]]];
    end

    // way compare and free-way search, lowest way first
    logic             w_hit, w_free_found;
    logic [PPN_W-1:0] w_tlb_page;

    always_comb begin
        w_hit        = 1'b0;
        w_tlb_page   = '0;
        w_free_found = 1'b0;
        w_fill_way   = '0;
        for (int w = 0; w < TLB_WAYS; w++) begin
            if (!w_hit && w_tlb_rd[w].valid && w_tlb_rd[w].tag == r_va_tag) begin
                w_hit      = 1'b1;
                w_tlb_page = w_tlb_rd[w].page;
            end
            if (!w_free_found && !w_tlb_rd[w].valid) begin
                w_free_found  = 1'b1;
                w_fill_way[w] = 1'b1;
            end
        end
    end

    logic [PPN_W-1:0]  w_page;
    logic              w_det;
    logic [BYTE_W-1:0] w_byte;

    assign w_page = w_hit ? w_tlb_page : r_pt_rd;
    assign w_det  = r_line_rd.valid && (r_line_rd.tag == w_page);

    always_comb begin
        case (r_offset)
            2'd0:    w_byte = r_line_rd.data[0*BYTE_W +: BYTE_W];
            2'd1:    w_byte = r_line_rd.data[1*BYTE_W +: BYTE_W];
            2'd2:    w_byte = r_line_rd.data[2*BYTE_W +: BYTE_W];
            default: w_byte = r_line_rd.data[3*BYTE_W +: BYTE_W];
        endcase
    end

    // response register
    logic r_out_valid, n_out_valid;
    t_rsp r_out;

    assign n_out_valid = i_cmd.out_load || (r_out_valid && !i_rsp_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.data_byte       <= w_det ? w_byte : '0;
            r_out.determined      <= w_det;
            r_out.translated_page <= w_page;
        end
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_rsp          = r_out;
    assign o_sts.out_free = !r_out_valid || i_rsp_ready;
    assign o_sts.clr_last = (r_clr_idx == CLR_W'(CLR_DEPTH - 1));

endmodule

// ===== rtl/tlb_cache_address_translator.sv =====
// ----------------------------------------------------------------------------
// tlb_cache_address_translator
// Virtual address translation through a set-associative TLB and a page
// table, followed by a direct-mapped cache lookup.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: a read of a 14-bit virtual address, or a load
//   of a TLB entry, a page table entry or a cache line. o_rsp returns one
//   response per read (byte, determined flag, translated page); loads return
//   nothing.
//   A read captures first: the TLB ways, the page table and the cache line
//   memory are read at once into registers. The execute state then compares
//   the ways and the line tag and loads the response register, which drives
//   the response valid. A TLB load reads the set at capture, then writes the
//   first free way in the execute state; page table and cache line loads
//   write at capture. After reset a clearing pass over max(TLB_SETS,
//   PAGE_ENTRIES, CACHE_LINES) entries (256 by default) zeroes the stores;
//   i_req.ready stays low then. If the receiver stalls, the response is held
//   in the output register and the next request is still taken; a following
//   read waits in its compare cycle until the register frees up.
// ----------------------------------------------------------------------------
module tlb_cache_address_translator #(
    parameter int TLB_SETS     = tcat_pkg::DEF_TLB_SETS,
    parameter int TLB_WAYS     = tcat_pkg::DEF_TLB_WAYS,
    parameter int PAGE_ENTRIES = tcat_pkg::DEF_PAGE_ENTRIES,
    parameter int CACHE_LINES  = tcat_pkg::DEF_CACHE_LINES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tcat_req_if.sink          i_req,
    tcat_rsp_if.source        o_rsp
);
    import tcat_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tcat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_kind  (i_req.payload.kind),
        .i_sts       (w_sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd)
    );

    tcat_dp #(
        .TLB_SETS     (TLB_SETS),
        .TLB_WAYS     (TLB_WAYS),
        .PAGE_ENTRIES (PAGE_ENTRIES),
        .CACHE_LINES  (CACHE_LINES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (i_req.payload),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp       (o_rsp.payload),
        .o_sts       (w_sts)
    );

`ifndef NO_ASSERTIONS
    // response register is only loaded when it is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("response register overwritten while full");

    // a read occupies the block for its compare cycle
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.payload.kind == KIND_READ) |=> !i_req.ready)
        else $error("request taken during read compare");

    // no request is taken right after reset: clearing pass runs first
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_req.ready)
        else $error("request taken before clearing pass");

    // undetermined responses carry a zero byte
    a_undet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.payload.determined) |-> (o_rsp.payload.data_byte == '0))
        else $error("nonzero byte on undetermined response");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the address translator. Requests (reads and TLB,
// page table and cache line loads) are queued up front and sent through a
// valid/ready driver with random gaps. A scoreboard mirrors the TLB, page
// table and cache, predicts one response per accepted read, and checks every
// response field against it. Both sides stall at random, the response side
// holds off once for a long stretch, and the sender drains once mid-run.
// ----------------------------------------------------------------------------
module tb;
    import tcat_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int HOLD_AT_RESULT = 150;
    localparam int LONG_HOLD      = 400;
    localparam int PAUSE_AT_ITEM  = 700;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic [VA_W-1:0] va;
        t_rsp            rsp;
    } t_expected;

    logic i_clk;
    logic i_rst_n;

    tcat_req_if req_ch();
    tcat_rsp_if rsp_ch();

    tlb_cache_address_translator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // mirror of the translator's stores
    logic              tlb_vld [DEF_TLB_SETS][DEF_TLB_WAYS];
    logic [TAG_W-1:0]  tlb_tag [DEF_TLB_SETS][DEF_TLB_WAYS];
    logic [PPN_W-1:0]  tlb_ppn [DEF_TLB_SETS][DEF_TLB_WAYS];
    logic [PPN_W-1:0]  page_tbl [DEF_PAGE_ENTRIES];
    logic              line_vld [DEF_CACHE_LINES];
    logic [TAG_W-1:0]  line_tag [DEF_CACHE_LINES];
    logic [LDATA_W-1:0] line_bytes [DEF_CACHE_LINES];

    t_expected pending_rsp_q[$];
    t_req      req_q[$];

    // what the generator has put into each TLB set so far
    int               issued_tlb_cnt [DEF_TLB_SETS];
    logic [TAG_W-1:0] issued_tlb_tag [DEF_TLB_SETS][DEF_TLB_WAYS];
    logic [PPN_W-1:0] issued_tlb_ppn [DEF_TLB_SETS][DEF_TLB_WAYS];

    int n_queued, n_total, n_sent, n_accepted, n_results, n_errors, n_cycles;
    int n_reads, n_loads, n_tlb_hits, n_determined, n_dropped;
    int send_gap, stall_left, hold_left;

    function automatic void clear_mirror();
        for (int s = 0; s < DEF_TLB_SETS; s++) begin
            issued_tlb_cnt[s] = 0;
            for (int w = 0; w < DEF_TLB_WAYS; w++) begin
                tlb_vld[s][w] = 1'b0;
                tlb_tag[s][w] = '0;
                tlb_ppn[s][w] = '0;
            end
        end
        foreach (page_tbl[i]) page_tbl[i] = '0;
        for (int i = 0; i < DEF_CACHE_LINES; i++) begin
            line_vld[i]   = 1'b0;
            line_tag[i]   = '0;
            line_bytes[i] = '0;
        end
    endfunction

    function automatic t_rsp translate(logic [VA_W-1:0] va);
        logic [VPN_W-1:0]  vpn;
        logic [TAG_W-1:0]  tag;
        logic [SET_W-1:0]  tset;
        logic [LIDX_W-1:0] idx;
        logic [OFFS_W-1:0] off;
        logic              hit;
        t_rsp              r;
        vpn  = va[VA_W-1:VA_VPN_LSB];
        tag  = va[VA_W-1:VA_TAG_LSB];
        tset = vpn[SET_W-1:0];
        idx  = va[VA_VPN_LSB-1:VA_LINE_LSB];
        off  = va[OFFS_W-1:0];
        hit  = 1'b0;
        r.translated_page = page_tbl[vpn];
        // lowest valid matching way wins
        for (int w = 0; w < DEF_TLB_WAYS; w++) begin
            if (!hit && tlb_vld[tset][w] && tlb_tag[tset][w] == tag) begin
                hit = 1'b1;
                r.translated_page = tlb_ppn[tset][w];
            end
        end
        r.determined = line_vld[idx] && line_tag[idx] == r.translated_page;
        r.data_byte  = r.determined ? line_bytes[idx][off*BYTE_W +: BYTE_W] : '0;
        if (hit) n_tlb_hits++;
        if (r.determined) n_determined++;
        return r;
    endfunction

    function automatic void apply_request(t_req r);
        t_expected e;
        logic      placed;
        case (r.kind)
            KIND_READ: begin
                e.va  = r.virtual_address;
                e.rsp = translate(r.virtual_address);
                pending_rsp_q.push_back(e);
                n_reads++;
            end
            KIND_LOAD_TLB: begin
                placed = 1'b0;
                for (int w = 0; w < DEF_TLB_WAYS; w++) begin
                    if (!placed && !tlb_vld[r.tlb_set][w]) begin
                        tlb_vld[r.tlb_set][w] = 1'b1;
                        tlb_tag[r.tlb_set][w] = r.entry_tag;
                        tlb_ppn[r.tlb_set][w] = r.physical_page;
                        placed = 1'b1;
                    end
                end
                if (placed) n_loads++;
                else n_dropped++;
            end
            KIND_LOAD_PAGE: begin
                page_tbl[r.virtual_page] = r.physical_page;
                n_loads++;
            end
            default: begin
                line_vld[r.line_index]   = 1'b1;
                line_tag[r.line_index]   = r.entry_tag;
                line_bytes[r.line_index] = r.line_data;
                n_loads++;
            end
        endcase
    endfunction

    function automatic void report_field(string field, logic [VA_W-1:0] va,
                                         logic [BYTE_W-1:0] exp_v,
                                         logic [BYTE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            $display("%0t: read 0x%h %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, va, field, exp_v, act_v);
        end
    endfunction

    function automatic void check_response(t_rsp got);
        t_expected e;
        if (pending_rsp_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected response: expected none, got byte 0x%h det %b page 0x%h",
                     $time, got.data_byte, got.determined, got.translated_page);
        end else begin
            e = pending_rsp_q.pop_front();
            report_field("data_byte", e.va, e.rsp.data_byte, got.data_byte);
            report_field("determined", e.va, BYTE_W'(e.rsp.determined),
                         BYTE_W'(got.determined));
            report_field("translated_page", e.va, BYTE_W'(e.rsp.translated_page),
                         BYTE_W'(got.translated_page));
        end
    endfunction

    // ---- stimulus helpers: unused fields always carry random bits ----
    function automatic t_req random_req(t_kind k);
        t_req r;
        r.kind            = k;
        r.virtual_address = VA_W'($urandom);
        r.tlb_set         = SET_W'($urandom);
        r.entry_tag       = TAG_W'($urandom);
        r.virtual_page    = VPN_W'($urandom);
        r.physical_page   = PPN_W'($urandom);
        r.line_index      = LIDX_W'($urandom);
        r.line_data       = $urandom;
        return r;
    endfunction

    function automatic void queue_req(t_req r);
        req_q.push_back(r);
        if (r.kind == KIND_LOAD_TLB) begin
            // a load into a full set is dropped and does not count
            if (issued_tlb_cnt[r.tlb_set] < DEF_TLB_WAYS) begin
                issued_tlb_tag[r.tlb_set][issued_tlb_cnt[r.tlb_set]] = r.entry_tag;
                issued_tlb_ppn[r.tlb_set][issued_tlb_cnt[r.tlb_set]] = r.physical_page;
                issued_tlb_cnt[r.tlb_set]++;
                n_queued++;
            end
        end else begin
            n_queued++;
        end
    endfunction

    function automatic void read_va(logic [VA_W-1:0] va);
        t_req r;
        r = random_req(KIND_READ);
        r.virtual_address = va;
        queue_req(r);
    endfunction

    function automatic void load_tlb(logic [SET_W-1:0] tset, logic [TAG_W-1:0] tag,
                                     logic [PPN_W-1:0] ppn);
        t_req r;
        r = random_req(KIND_LOAD_TLB);
        r.tlb_set       = tset;
        r.entry_tag     = tag;
        r.physical_page = ppn;
        queue_req(r);
    endfunction

    function automatic void load_page(logic [VPN_W-1:0] vpn, logic [PPN_W-1:0] ppn);
        t_req r;
        r = random_req(KIND_LOAD_PAGE);
        r.virtual_page  = vpn;
        r.physical_page = ppn;
        queue_req(r);
    endfunction

    function automatic void load_line(logic [LIDX_W-1:0] idx, logic [TAG_W-1:0] tag,
                                      logic [LDATA_W-1:0] data);
        t_req r;
        r = random_req(KIND_LOAD_LINE);
        r.line_index = idx;
        r.entry_tag  = tag;
        r.line_data  = data;
        queue_req(r);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                apply_request(req_ch.payload);
                n_accepted++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (n_sent == PAUSE_AT_ITEM && pending_rsp_q.size() != 0) begin
                    // drain every outstanding response before going on
                    req_ch.valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    req_ch.payload <= req_q.pop_front();
                    req_ch.valid   <= 1'b1;
                    n_sent++;
                    send_gap = ((n_sent / 100) % 4 == 2) ? 0 : $urandom_range(0, 4);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                check_response(rsp_ch.payload);
                n_results++;
                if (n_results == HOLD_AT_RESULT)
                    hold_left = LONG_HOLD;
                else
                    stall_left = ((n_results / 60) % 3 == 1) ? 0 : $urandom_range(0, 4);
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tlb_cache_address_translator verification failed");
            $finish;
        end
    end

    initial begin
        logic [VPN_W-1:0]  vpn;
        logic [PPN_W-1:0]  ppn;
        logic [TAG_W-1:0]  tag;
        logic [SET_W-1:0]  tset;
        logic [LIDX_W-1:0] idx;
        int                n_directed;
        int                w;

        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        send_gap   = 0;
        stall_left = 0;
        hold_left  = 0;
        clear_mirror();

        // empty stores: page 0, nothing determined
        read_va(14'h0000);
        read_va(14'h3fff);
        // line 0 tagged with page 0, every byte offset
        load_line(4'd0, 6'd0, 32'h8040_2001);
        for (int o = 0; o < 4; o++) read_va(VA_W'(o));
        // page table extremes
        load_page(8'hff, 6'h3f);
        load_line(4'hf, 6'h3f, 32'hffff_ffff);
        read_va(14'h3fff);
        // TLB overrides the page table, line tag then misses
        load_tlb(2'd3, 6'h3f, 6'd5);
        read_va(14'h3fff);
        // fill set 0: duplicate tag, then a load into the full set
        load_tlb(2'd0, 6'd0, 6'd0);
        load_tlb(2'd0, 6'd0, 6'd1);
        load_tlb(2'd0, 6'd1, 6'd2);
        load_tlb(2'd0, 6'd2, 6'd3);
        load_tlb(2'd0, 6'd3, 6'd4);
        read_va(14'h0000);
        read_va(14'h0300);
        read_va(14'h0200);
        read_va(14'h0101);
        n_directed = n_queued;

        while (n_queued < n_directed + RANDOM_ITEMS) begin
            vpn  = VPN_W'($urandom);
            ppn  = PPN_W'($urandom);
            tag  = TAG_W'($urandom);
            tset = SET_W'($urandom);
            idx  = LIDX_W'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // walk through the page table into a matching line
                    load_page(vpn, ppn);
                    load_line(idx, ppn, $urandom);
                    repeat ($urandom_range(1, 3)) read_va({vpn, idx, 2'($urandom)});
                end
                3, 4: begin
                    // TLB hit path: a new entry at random while the set has room, else an issued one is reused if any
                    if (issued_tlb_cnt[tset] < DEF_TLB_WAYS && $urandom_range(0, 1)) begin
                        load_tlb(tset, tag, ppn);
                    end else if (issued_tlb_cnt[tset] > 0) begin
                        w   = $urandom_range(0, issued_tlb_cnt[tset] - 1);
                        tag = issued_tlb_tag[tset][w];
                        ppn = issued_tlb_ppn[tset][w];
                    end
                    load_line(idx, ppn, $urandom);
                    repeat ($urandom_range(1, 3)) read_va({tag, tset, idx, 2'($urandom)});
                end
                5, 6: begin
                    repeat ($urandom_range(1, 3)) read_va(VA_W'($urandom));
                end
                7: begin
                    // page loaded, the read lands on a random line
                    load_page(vpn, ppn);
                    read_va({vpn, 4'($urandom), 2'($urandom)});
                end
                default: begin
                    queue_req(random_req(t_kind'($urandom_range(0, 3))));
                end
            endcase
        end
        n_total = req_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d reads (%0d through the TLB, %0d determined) and %0d loads",
                 n_reads, n_tlb_hits, n_determined, n_loads);
        $display("%0d TLB loads dropped on full sets, %0d responses checked",
                 n_dropped, n_results);
        if (n_errors == 0) begin
            $display("tlb_cache_address_translator verification clean");
        end else begin
            $display("tlb_cache_address_translator verification failed");
        end
        $finish;
    end

endmodule
